// ===== sv/ebg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ebg_pkg: shared constants and types of the epsilon-greedy bandit unit
// Widths, register indexes and the controller/datapath command bundles.
// ============================================================================
package ebg_pkg;

    // Arm set and count sizing
    localparam int NUM_ARMS   = 4;
    localparam int COUNT_BITS = 16;
    localparam int ARM_W      = 2;
    localparam int ARM_CMP_W  = ARM_W + 1;
    localparam int IDX_W      = (NUM_ARMS > 2) ? $clog2(NUM_ARMS) : 1;

    // Field widths
    localparam int EPS_W      = 16;
    localparam int WARM_W     = 8;
    localparam int SEEN_W     = 8;
    localparam int REWARD_W   = 32;
    localparam int CNT_OUT_W  = 16;
    localparam int CNT_EXT_W  = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
    localparam int RAND_W     = EPS_W + ARM_W;

    // Divider sizing: magnitude of a 33-bit difference, signed quotient
    localparam int DIVIDEND_W = REWARD_W + 1;
    localparam int QUO_W      = DIVIDEND_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd6554;
    localparam logic [WARM_W-1:0] WARM_RESET = 8'd5;

    typedef enum logic [0:0] {
        REG_EPSILON = 1'b0,
        REG_WARMUP  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic write_est;
        logic emit;
    } ebg_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } ebg_status_t;

endpackage
`default_nettype wire

// ===== sv/ebg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ebg_div: serial restoring divider
// Divides an unsigned magnitude by the arm count, one quotient bit a cycle,
// and applies the sign so the quotient truncates toward zero.
// ============================================================================
module ebg_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [ebg_pkg::DIVIDEND_W-1:0]        dividend_mag,
    input  wire logic                                  negate,
    input  wire logic [ebg_pkg::COUNT_BITS-1:0]        divisor,
    output logic                                       busy,
    output logic                                       done,
    output logic signed [ebg_pkg::QUO_W-1:0]           quotient
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [ebg_pkg::DIV_CNT_W-1:0]         step_reg;
    logic [ebg_pkg::COUNT_BITS-1:0]        rem_reg;
    logic [ebg_pkg::DIVIDEND_W-1:0]        quo_reg;
    logic [ebg_pkg::COUNT_BITS-1:0]        dsr_reg;
    logic                                  neg_reg;

    logic [ebg_pkg::COUNT_BITS:0]          rem_shift;
    logic [ebg_pkg::COUNT_BITS:0]          rem_sub;
    logic                                  q_bit;
    logic [ebg_pkg::COUNT_BITS-1:0]        rem_next;
    logic [ebg_pkg::QUO_W-1:0]             quo_ext;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[ebg_pkg::DIVIDEND_W-1]};
        rem_sub   = rem_shift - {1'b0, dsr_reg};
        q_bit     = (rem_shift >= {1'b0, dsr_reg});
        rem_next  = q_bit ? rem_sub[ebg_pkg::COUNT_BITS-1:0]
                          : rem_shift[ebg_pkg::COUNT_BITS-1:0];
        quo_ext   = {1'b0, quo_reg};
    end

    // Step counter and handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ebg_pkg::DIV_CNT_W'(ebg_pkg::DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - ebg_pkg::DIV_CNT_W'(1);
                if (step_reg == ebg_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend_mag;
            dsr_reg <= divisor;
            neg_reg <= negate;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ebg_pkg::DIVIDEND_W-2:0], q_bit};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-quo_ext) : $signed(quo_ext);

endmodule
`default_nettype wire

// ===== sv/ebg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ebg_ctrl: bandit sequencer
// Steps each item through decode, optional division and result hand-off.
// ============================================================================
module ebg_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire ebg_pkg::ebg_status_t status,
    output ebg_pkg::ebg_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd.load      = in_valid && (state_reg == ST_IDLE);
        cmd.exec      = (state_reg == ST_EXEC);
        cmd.write_est = (state_reg == ST_DIV) && status.div_done;
        cmd.emit      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = status.need_div ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== sv/ebg_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ebg_datapath: estimate and count storage, arm choice and update arithmetic
// Holds the per-arm state, the captured item and the output register.
// ============================================================================
module ebg_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ebg_pkg::ebg_cmd_t                    cmd,
    output ebg_pkg::ebg_status_t                      status,
    input  wire logic [ebg_pkg::EPS_W-1:0]            epsilon_threshold,
    input  wire logic [ebg_pkg::WARM_W-1:0]           warmup_updates,
    input  wire logic                                 req_type,
    input  wire logic [ebg_pkg::EPS_W-1:0]            explore_draw,
    input  wire logic [ebg_pkg::EPS_W-1:0]            tie_draw,
    input  wire logic [ebg_pkg::ARM_W-1:0]            chosen_arm,
    input  wire logic signed [ebg_pkg::REWARD_W-1:0]  reward_value,
    output logic [ebg_pkg::ARM_W-1:0]                 arm,
    output logic                                      explored,
    output logic signed [ebg_pkg::REWARD_W-1:0]       estimate,
    output logic [ebg_pkg::CNT_OUT_W-1:0]             pull_count,
    output logic                                      skipped
);

    // Per-arm state
    logic signed [ebg_pkg::REWARD_W-1:0]   est_reg [ebg_pkg::NUM_ARMS];
    logic [ebg_pkg::COUNT_BITS-1:0]        cnt_reg [ebg_pkg::NUM_ARMS];
    logic [ebg_pkg::SEEN_W-1:0]            seen_reg;

    // Captured item
    logic                                  req_reg;
    logic [ebg_pkg::EPS_W-1:0]             edraw_reg;
    logic [ebg_pkg::EPS_W-1:0]             tdraw_reg;
    logic [ebg_pkg::ARM_W-1:0]             carm_reg;
    logic signed [ebg_pkg::REWARD_W-1:0]   reward_reg;

    // Decision of the current item
    logic [ebg_pkg::ARM_W-1:0]             sel_arm_reg;
    logic                                  sel_explored_reg;
    logic                                  sel_skipped_reg;
    logic                                  sel_oob_reg;

    // Output register
    logic [ebg_pkg::ARM_W-1:0]             out_arm_reg;
    logic                                  out_explored_reg;
    logic signed [ebg_pkg::REWARD_W-1:0]   out_est_reg;
    logic [ebg_pkg::CNT_OUT_W-1:0]         out_cnt_reg;
    logic                                  out_skipped_reg;

    logic                                  is_best;
    logic                                  found;
    logic [ebg_pkg::ARM_W-1:0]             best_arm;
    logic                                  exploit;
    logic [ebg_pkg::RAND_W-1:0]            rand_prod;
    logic [ebg_pkg::ARM_W-1:0]             rand_arm;
    logic [ebg_pkg::ARM_W-1:0]             pick_arm;
    logic                                  pick_explored;

    logic                                  carm_oob;
    logic                                  in_warmup;
    logic [ebg_pkg::SEEN_W-1:0]            seen_inc;

    logic [ebg_pkg::ARM_W-1:0]             rd_arm;
    logic [ebg_pkg::IDX_W-1:0]             rd_idx;
    logic signed [ebg_pkg::REWARD_W-1:0]   rd_est;
    logic [ebg_pkg::COUNT_BITS-1:0]        rd_cnt;
    logic [ebg_pkg::COUNT_BITS-1:0]        cnt_inc;
    logic [ebg_pkg::CNT_EXT_W-1:0]         cnt_ext;
    logic [ebg_pkg::CNT_OUT_W-1:0]         cnt_shown;

    logic signed [ebg_pkg::DIVIDEND_W-1:0] diff;
    logic [ebg_pkg::DIVIDEND_W-1:0]        diff_neg;
    logic [ebg_pkg::DIVIDEND_W-1:0]        diff_mag;
    logic                                  div_start;
    logic                                  div_busy;
    logic                                  div_done;
    logic signed [ebg_pkg::QUO_W-1:0]      quotient;
    logic signed [ebg_pkg::QUO_W-1:0]      est_sum;

    // Strict maximum over the estimates
    always_comb
    begin
        found    = 1'b0;
        best_arm = '0;
        is_best  = 1'b0;
        for (int i = 0; i < ebg_pkg::NUM_ARMS; i++)
        begin
            is_best = 1'b1;
            for (int j = 0; j < ebg_pkg::NUM_ARMS; j++)
            begin
                if ((j != i) && !(est_reg[i] > est_reg[j]))
                begin
                    is_best = 1'b0;
                end
            end
            if (is_best && !found)
            begin
                found    = 1'b1;
                best_arm = ebg_pkg::ARM_W'(i);
            end
        end
    end

    always_comb
    begin
        exploit       = (edraw_reg > epsilon_threshold);
        rand_prod     = ebg_pkg::RAND_W'(tdraw_reg) * ebg_pkg::RAND_W'(ebg_pkg::NUM_ARMS);
        rand_arm      = rand_prod[ebg_pkg::RAND_W-1:ebg_pkg::EPS_W];
        pick_explored = !(exploit && found);
        pick_arm      = pick_explored ? rand_arm : best_arm;

        carm_oob  = ({1'b0, carm_reg} >= ebg_pkg::ARM_CMP_W'(ebg_pkg::NUM_ARMS));
        in_warmup = (seen_reg < warmup_updates);
        seen_inc  = (seen_reg == ebg_pkg::SEEN_MAX) ? seen_reg
                                                    : seen_reg + ebg_pkg::SEEN_W'(1);
    end

    // Single read port into the arm state: captured arm while deciding,
    // decided arm afterwards
    always_comb
    begin
        rd_arm  = cmd.exec ? carm_reg : sel_arm_reg;
        rd_idx  = rd_arm[ebg_pkg::IDX_W-1:0];
        rd_est  = est_reg[rd_idx];
        rd_cnt  = cnt_reg[rd_idx];
        cnt_inc = (rd_cnt == {ebg_pkg::COUNT_BITS{1'b1}}) ? rd_cnt
                                                          : rd_cnt + ebg_pkg::COUNT_BITS'(1);
        cnt_ext   = ebg_pkg::CNT_EXT_W'(rd_cnt);
        cnt_shown = (cnt_ext > ebg_pkg::CNT_EXT_W'({ebg_pkg::CNT_OUT_W{1'b1}}))
                    ? {ebg_pkg::CNT_OUT_W{1'b1}} : cnt_ext[ebg_pkg::CNT_OUT_W-1:0];
    end

    always_comb
    begin
        diff     = $signed({reward_reg[ebg_pkg::REWARD_W-1], reward_reg})
                 - $signed({rd_est[ebg_pkg::REWARD_W-1], rd_est});
        diff_neg = -diff;
        diff_mag = diff[ebg_pkg::DIVIDEND_W-1] ? diff_neg : diff;
        est_sum  = $signed({{(ebg_pkg::QUO_W - ebg_pkg::REWARD_W){rd_est[ebg_pkg::REWARD_W-1]}},
                            rd_est}) + quotient;
    end

    assign status.need_div = req_reg && !carm_oob && !in_warmup;
    assign status.div_done = div_done;
    assign div_start       = cmd.exec && status.need_div;

    ebg_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (diff_mag),
        .negate       (diff[ebg_pkg::DIVIDEND_W-1]),
        .divisor      (cnt_inc),
        .busy         (div_busy),
        .done         (div_done),
        .quotient     (quotient)
    );

    // Arm state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ebg_pkg::NUM_ARMS; i++)
            begin
                est_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
            seen_reg <= '0;
        end
        else
        begin
            if (cmd.exec && req_reg && !carm_oob)
            begin
                seen_reg <= seen_inc;
                if (!in_warmup)
                begin
                    cnt_reg[rd_idx] <= cnt_inc;
                end
            end
            if (cmd.write_est)
            begin
                est_reg[rd_idx] <= est_sum[ebg_pkg::REWARD_W-1:0];
            end
        end
    end

    // Item capture, decision and output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_type;
            edraw_reg  <= explore_draw;
            tdraw_reg  <= tie_draw;
            carm_reg   <= chosen_arm;
            reward_reg <= reward_value;
        end
        if (cmd.exec)
        begin
            if (!req_reg)
            begin
                sel_arm_reg      <= pick_arm;
                sel_explored_reg <= pick_explored;
                sel_skipped_reg  <= 1'b0;
                sel_oob_reg      <= 1'b0;
            end
            else
            begin
                sel_arm_reg      <= carm_reg;
                sel_explored_reg <= 1'b0;
                sel_skipped_reg  <= !carm_oob && in_warmup;
                sel_oob_reg      <= carm_oob;
            end
        end
        if (cmd.emit)
        begin
            out_arm_reg      <= sel_arm_reg;
            out_explored_reg <= sel_explored_reg;
            out_skipped_reg  <= sel_skipped_reg;
            out_est_reg      <= sel_oob_reg ? '0 : rd_est;
            out_cnt_reg      <= sel_oob_reg ? '0 : cnt_shown;
        end
    end

    assign arm        = out_arm_reg;
    assign explored   = out_explored_reg;
    assign estimate   = out_est_reg;
    assign pull_count = out_cnt_reg;
    assign skipped    = out_skipped_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_seen_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (seen_reg >= $past(seen_reg)))
        else $error("update counter went backwards");

    a_write_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_est |-> (req_reg && !sel_oob_reg && !sel_skipped_reg))
        else $error("estimate written for an item that needs no update");

    a_decision_flags: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(sel_explored_reg && sel_skipped_reg))
        else $error("result both explored and skipped");

endmodule
`default_nettype wire

// ===== sv/epsilon_greedy_bandit_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: a select item, an ignored update or a warmup update goes from decode to the output
//   register; a counted update first passes through the 33-step serial divider (one quotient
//   bit a cycle). A new item is accepted only after the last one has been handed to the
//   output register, and a stalled result register holds off the next beat.
// Reset: rst_n clears estimates, counts, the update counter and the control state, and
//   loads epsilon_threshold = 6554 and warmup_updates = 5.
// ============================================================================
// epsilon_greedy_bandit_unit: four-armed epsilon-greedy bandit, sample average
// Picks an arm by explore draw, strict maximum or tie draw, and folds Q16.16
// rewards into per-arm running means. Configuration through an APB-style port.
// ============================================================================
module epsilon_greedy_bandit_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [ebg_pkg::PADDR_W-1:0]          paddr,
    input  wire logic [ebg_pkg::PDATA_W-1:0]          pwdata,
    output logic [ebg_pkg::PDATA_W-1:0]               prdata,
    output logic                                      pready,
    // Request channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 req_type,
    input  wire logic [ebg_pkg::EPS_W-1:0]            explore_draw,
    input  wire logic [ebg_pkg::EPS_W-1:0]            tie_draw,
    input  wire logic [ebg_pkg::ARM_W-1:0]            chosen_arm,
    input  wire logic signed [ebg_pkg::REWARD_W-1:0]  reward_value,
    // Result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [ebg_pkg::ARM_W-1:0]                 arm,
    output logic                                      explored,
    output logic signed [ebg_pkg::REWARD_W-1:0]       estimate,
    output logic [ebg_pkg::CNT_OUT_W-1:0]             pull_count,
    output logic                                      skipped
);

    logic [ebg_pkg::EPS_W-1:0]  eps_reg;
    logic [ebg_pkg::WARM_W-1:0] warm_reg;
    logic                       cfg_write;
    ebg_pkg::reg_idx_t          cfg_idx;

    ebg_pkg::ebg_cmd_t          cmd;
    ebg_pkg::ebg_status_t       status;

    // Register map: epsilon at byte 0, warmup at byte 4. Only bit 2 of the
    // address selects; the port never stalls.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = ebg_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= ebg_pkg::EPS_RESET;
            warm_reg <= ebg_pkg::WARM_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                ebg_pkg::REG_EPSILON: eps_reg  <= pwdata[ebg_pkg::EPS_W-1:0];
                ebg_pkg::REG_WARMUP:  warm_reg <= pwdata[ebg_pkg::WARM_W-1:0];
                default:              eps_reg  <= eps_reg;
            endcase
        end
    end

    // Read back zero-extended register contents
    always_comb
    begin
        unique case (cfg_idx)
            ebg_pkg::REG_EPSILON: prdata = ebg_pkg::PDATA_W'(eps_reg);
            ebg_pkg::REG_WARMUP:  prdata = ebg_pkg::PDATA_W'(warm_reg);
            default:              prdata = '0;
        endcase
    end

    // Sequencer: accept a beat when idle, decide, divide if the update counts,
    // then hand the result to the output register once it is free.
    ebg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: arm state, arm choice, divider and the output payload register
    ebg_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .epsilon_threshold (eps_reg),
        .warmup_updates    (warm_reg),
        .req_type          (req_type),
        .explore_draw      (explore_draw),
        .tie_draw          (tie_draw),
        .chosen_arm        (chosen_arm),
        .reward_value      (reward_value),
        .arm               (arm),
        .explored          (explored),
        .estimate          (estimate),
        .pull_count        (pull_count),
        .skipped           (skipped)
    );

endmodule
`default_nettype wire

// ===== tb/sv/ebg_tb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ebg_tb_pkg: request and result beat types for the bandit unit testbench
// Request kinds, register stride and the packed beats that the stimulus
// and the scoreboard exchange.
// ============================================================================
package ebg_tb_pkg;

    typedef enum logic {
        REQ_SELECT = 1'b0,
        REQ_UPDATE = 1'b1
    } req_kind_t;

    // Byte distance between two configuration registers
    localparam int REG_STRIDE = 4;

    typedef struct packed {
        req_kind_t                               kind;
        logic [ebg_pkg::EPS_W-1:0]               explore_draw;
        logic [ebg_pkg::EPS_W-1:0]               tie_draw;
        logic [ebg_pkg::ARM_W-1:0]               arm;
        logic signed [ebg_pkg::REWARD_W-1:0]     reward;
    } bandit_req_t;

    typedef struct packed {
        logic [ebg_pkg::ARM_W-1:0]               arm;
        logic                                    explored;
        logic signed [ebg_pkg::REWARD_W-1:0]     estimate;
        logic [ebg_pkg::CNT_OUT_W-1:0]           pull_count;
        logic                                    skipped;
    } bandit_result_t;

endpackage

// ===== tb/sv/ebg_scoreboard.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ebg_scoreboard: arm choice and running-mean predictor with result checking
// Tracks register writes, predicts one result beat per accepted request and
// compares every accepted result beat with the oldest prediction.
// ============================================================================
module ebg_scoreboard
    import ebg_pkg::*;
    import ebg_tb_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [PADDR_W-1:0]          paddr,
    input  logic [PDATA_W-1:0]          pwdata,
    input  logic [PDATA_W-1:0]          prdata,
    input  logic                        pready,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic                        req_type,
    input  logic [EPS_W-1:0]            explore_draw,
    input  logic [EPS_W-1:0]            tie_draw,
    input  logic [ARM_W-1:0]            chosen_arm,
    input  logic signed [REWARD_W-1:0]  reward_value,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [ARM_W-1:0]            arm,
    input  logic                        explored,
    input  logic signed [REWARD_W-1:0]  estimate,
    input  logic [CNT_OUT_W-1:0]        pull_count,
    input  logic                        skipped,
    output int                          mismatches,
    output int                          pending_results
);

    localparam longint PULL_CAP = (longint'(1) << CNT_OUT_W) - 1;

    logic [EPS_W-1:0]            eps_model;
    logic [WARM_W-1:0]           warm_model;
    logic signed [REWARD_W-1:0]  est_model [NUM_ARMS];
    logic [COUNT_BITS-1:0]       cnt_model [NUM_ARMS];
    logic [SEEN_W-1:0]           seen_model;
    bandit_result_t              expected_q [$];
    int                          fail_total = 0;

    function automatic logic [CNT_OUT_W-1:0] shown_count(input logic [COUNT_BITS-1:0] c);
        return (longint'(c) > PULL_CAP) ? CNT_OUT_W'(PULL_CAP) : CNT_OUT_W'(c);
    endfunction

    // Advance the arm state by one request and return the beat it should produce
    function automatic bandit_result_t predict_bandit(input bandit_req_t r);
        bandit_result_t res;
        int unsigned    scaled;
        int             pick;
        int             a;
        bit             found;
        bit             best;
        longint         diff;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        if (r.kind == REQ_SELECT) begin
            // Exploit only when one arm strictly beats all the others
            if (r.explore_draw > eps_model) begin
                for (int i = 0; i < NUM_ARMS; i++) begin
                    best = 1'b1;
                    for (int j = 0; j < NUM_ARMS; j++)
                        if (j != i && !(est_model[i] > est_model[j]))
                            best = 1'b0;
                    if (best && !found) begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                scaled = r.tie_draw * NUM_ARMS;
                pick   = int'(scaled >> 16);
            end
            if (pick >= NUM_ARMS)
                pick = NUM_ARMS - 1;
            res.arm        = ARM_W'(pick);
            res.explored   = !found;
            res.estimate   = est_model[pick];
            res.pull_count = shown_count(cnt_model[pick]);
            return res;
        end
        a       = int'(r.arm);
        res.arm = r.arm;
        if (a >= NUM_ARMS)
            return res;
        // Warmup: count the update, leave the estimate alone
        if (seen_model < warm_model) begin
            if (seen_model != SEEN_MAX)
                seen_model++;
            res.estimate   = est_model[a];
            res.pull_count = shown_count(cnt_model[a]);
            res.skipped    = 1'b1;
            return res;
        end
        if (seen_model != SEEN_MAX)
            seen_model++;
        if (cnt_model[a] != {COUNT_BITS{1'b1}})
            cnt_model[a]++;
        diff         = longint'(r.reward) - longint'(est_model[a]);
        est_model[a] = REWARD_W'(longint'(est_model[a]) + diff / longint'(cnt_model[a]));
        res.estimate   = est_model[a];
        res.pull_count = shown_count(cnt_model[a]);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got, inout int bad);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%h got 0x%h", $time, name, want, got);
            bad++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        bandit_req_t    req;
        bandit_result_t want;
        reg_idx_t       idx;
        int             bad;
        if (!rst_n) begin
            eps_model  = EPS_RESET;
            warm_model = WARM_RESET;
            seen_model = '0;
            for (int i = 0; i < NUM_ARMS; i++) begin
                est_model[i] = '0;
                cnt_model[i] = '0;
            end
            expected_q.delete();
        end else begin
            // Register port: track writes, check read data
            if (psel && penable && pready) begin
                idx = reg_idx_t'(paddr / REG_STRIDE);
                bad = 0;
                if (pwrite) begin
                    if (idx == REG_EPSILON)
                        eps_model = pwdata[EPS_W-1:0];
                    else
                        warm_model = pwdata[WARM_W-1:0];
                end else if (idx == REG_EPSILON) begin
                    check_field("epsilon_threshold read", PDATA_W'(eps_model), prdata, bad);
                end else begin
                    check_field("warmup_updates read", PDATA_W'(warm_model), prdata, bad);
                end
                if (bad != 0)
                    fail_total++;
            end
            // Result beat: compare with the oldest prediction
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, arm %0d estimate 0x%h",
                             $time, arm, estimate);
                    fail_total++;
                end else begin
                    want = expected_q.pop_front();
                    bad  = 0;
                    check_field("arm", want.arm, arm, bad);
                    check_field("explored", want.explored, explored, bad);
                    check_field("estimate", $signed(want.estimate), $signed(estimate), bad);
                    check_field("pull_count", want.pull_count, pull_count, bad);
                    check_field("skipped", want.skipped, skipped, bad);
                    if (bad != 0)
                        fail_total++;
                end
            end
            // Request beat: predict its result
            if (in_valid && in_ready) begin
                req.kind         = (req_type == REQ_UPDATE) ? REQ_UPDATE : REQ_SELECT;
                req.explore_draw = explore_draw;
                req.tie_draw     = tie_draw;
                req.arm          = chosen_arm;
                req.reward       = reward_value;
                expected_q.push_back(predict_bandit(req));
            end
        end
        mismatches      <= fail_total;
        pending_results <= expected_q.size();
    end

endmodule

// ===== tb/sv/tb_epsilon_greedy_bandit_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_epsilon_greedy_bandit_unit: regression for the epsilon-greedy bandit unit
// Drives directed and random select/update beats through several register
// settings with bursty input and a stalling result sink; the scoreboard
// predicts and checks every result beat.
// ============================================================================
module tb_epsilon_greedy_bandit_unit;
    import ebg_pkg::*;
    import ebg_tb_pkg::*;

    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 245;
    localparam int HOLD_CYCLES     = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES   = 40;    // longer than a counted update

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [PADDR_W-1:0]          paddr;
    logic [PDATA_W-1:0]          pwdata;
    logic [PDATA_W-1:0]          prdata;
    logic                        pready;
    logic                        in_valid;
    logic                        in_ready;
    logic                        req_type;
    logic [EPS_W-1:0]            explore_draw;
    logic [EPS_W-1:0]            tie_draw;
    logic [ARM_W-1:0]            chosen_arm;
    logic signed [REWARD_W-1:0]  reward_value;
    logic                        out_valid;
    logic                        out_ready;
    logic [ARM_W-1:0]            arm;
    logic                        explored;
    logic signed [REWARD_W-1:0]  estimate;
    logic [CNT_OUT_W-1:0]        pull_count;
    logic                        skipped;
    int                          mismatches;
    int                          pending_results;

    // Handoff from the stimulus to the sink: request one long hold-off
    logic                        hold_req = 1'b0;
    // Current epsilon, kept so random draws can land right around it
    logic [EPS_W-1:0]            eps_cfg = EPS_RESET;
    // Beats left in the current input burst
    int                          burst_left = 0;

    epsilon_greedy_bandit_unit dut (.*);

    ebg_scoreboard u_scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // One register access: setup cycle, then access cycle until pready
    task automatic apb_access(input bit do_write, input reg_idx_t idx,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= do_write;
        paddr   <= PADDR_W'(REG_STRIDE * int'(idx));
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write both registers, then read them back through the port
    task automatic configure(input logic [EPS_W-1:0] eps, input logic [WARM_W-1:0] warm);
        apb_access(1'b1, REG_EPSILON, PDATA_W'(eps));
        apb_access(1'b1, REG_WARMUP, PDATA_W'(warm));
        apb_access(1'b0, REG_EPSILON, '0);
        apb_access(1'b0, REG_WARMUP, '0);
        eps_cfg = eps;
    endtask

    // Present one beat and hold it until accepted; open a new burst when the
    // current one is used up, possibly dropping valid for a random gap first
    task automatic offer(input bandit_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid     <= 1'b1;
        req_type     <= r.kind;
        explore_draw <= r.explore_draw;
        tie_draw     <= r.tie_draw;
        chosen_arm   <= r.arm;
        reward_value <= r.reward;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
    endtask

    // Stop sending and wait until every predicted beat has come back
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Fill the fields a beat does not use with noise so every bit toggles
    function automatic bandit_req_t noise_req(input req_kind_t kind);
        bandit_req_t r;
        r.kind         = kind;
        r.explore_draw = EPS_W'($urandom);
        r.tie_draw     = EPS_W'($urandom);
        r.arm          = ARM_W'($urandom);
        r.reward       = REWARD_W'($urandom);
        return r;
    endfunction

    function automatic bandit_req_t select_req(input logic [EPS_W-1:0] ed,
                                               input logic [EPS_W-1:0] td);
        bandit_req_t r;
        r              = noise_req(REQ_SELECT);
        r.explore_draw = ed;
        r.tie_draw     = td;
        return r;
    endfunction

    function automatic bandit_req_t update_req(input int a, input logic [31:0] rew);
        bandit_req_t r;
        r        = noise_req(REQ_UPDATE);
        r.arm    = ARM_W'(a);
        r.reward = rew;
        return r;
    endfunction

    function automatic bandit_req_t random_req();
        bandit_req_t r;
        int          near;
        r = noise_req(($urandom_range(0, 9) < 5) ? REQ_SELECT : REQ_UPDATE);
        // Explore draw: uniform, right around epsilon, or at the ends
        case ($urandom_range(0, 3))
            0:
            begin
                near = int'(eps_cfg) + int'($urandom_range(0, 2)) - 1;
                if (near < 0)
                    near = 0;
                if (near > 65535)
                    near = 65535;
                r.explore_draw = EPS_W'(near);
            end
            1: r.explore_draw = ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: ;
        endcase
        // Tie draw: sometimes on, just below or just above a quarter boundary
        if ($urandom_range(0, 9) < 3)
            r.tie_draw = EPS_W'(16'h4000 * $urandom_range(0, 3) + $urandom_range(0, 1)
                                - $urandom_range(0, 1));
        // Reward: full range, small Q16.16 values, extremes, moderate positives
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6: r.reward = REWARD_W'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            7: case ($urandom_range(0, 3))
                   0: r.reward = 32'sh7FFF_FFFF;
                   1: r.reward = 32'sh8000_0000;
                   2: r.reward = '0;
                   default: r.reward = -32'sd1;
               endcase
            default: r.reward = REWARD_W'($urandom_range(0, 32'h00FF_FFFF));
        endcase
        return r;
    endfunction

    // Result sink: stall on its own changing pattern; serve the hold-off request
    // once by keeping ready low for a long counted stretch
    initial
    begin : result_sink
        int mode;
        int span;
        bit hold_done;
        mode      = 0;
        span      = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(8, 80);
                end
                span--;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ~out_ready;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [EPS_W-1:0]  eps;
        logic [WARM_W-1:0] warm;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        in_valid     <= 1'b0;
        req_type     <= REQ_SELECT;
        explore_draw <= '0;
        tie_draw     <= '0;
        chosen_arm   <= '0;
        reward_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values through the read path
        apb_access(1'b0, REG_EPSILON, '0);
        apb_access(1'b0, REG_WARMUP, '0);

        // All estimates zero: every select is a tie, so walk the tie-draw
        // quarter boundaries and the explore draw around epsilon
        offer(select_req(16'hFFFF, 16'h0000));
        offer(select_req(16'h0000, 16'h3FFF));
        offer(select_req(16'd6554, 16'h4000));
        offer(select_req(16'd6555, 16'h7FFF));
        offer(select_req(16'hFFFF, 16'h8000));
        offer(select_req(16'hFFFF, 16'hBFFF));
        offer(select_req(16'hFFFF, 16'hC000));
        offer(select_req(16'hFFFF, 16'hFFFF));
        // Warmup eats the first five updates, extremes included
        offer(update_req(0, 32'h7FFF_FFFF));
        offer(update_req(1, 32'h8000_0000));
        offer(update_req(2, 32'h0000_0000));
        offer(update_req(3, 32'hFFFF_FFFF));
        offer(update_req(0, 32'h0000_0001));
        // Two arms pinned to the same estimate: exploit falls back to the draw
        offer(update_req(0, 32'h0003_0000));
        offer(update_req(1, 32'h0003_0000));
        offer(select_req(16'hFFFF, 16'h8000));
        // Largest reward makes a strict winner
        offer(update_req(2, 32'h7FFF_FFFF));
        offer(select_req(16'hFFFF, 16'h0000));
        // Most negative rewards: full-span difference on the second pull
        offer(update_req(3, 32'h8000_0000));
        offer(update_req(2, 32'h8000_0000));
        offer(select_req(16'hFFFF, 16'hC000));
        offer(update_req(0, 32'h7FFF_FFFF));
        offer(select_req(16'd6555, 16'h4000));
        offer(select_req(16'd6554, 16'h4000));
        offer(update_req(1, 32'hFFFF_FFFF));
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    eps  = '0;       // exploit almost always, long warmup
                    warm = '1;
                end
                1:
                begin
                    eps  = '1;       // always explore, no warmup
                    warm = '0;
                end
                2:
                begin
                    eps  = 16'h8000;
                    warm = 8'd3;
                end
                default:
                begin
                    eps  = EPS_W'($urandom);
                    warm = WARM_W'($urandom);
                end
            endcase
            configure(eps, warm);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Hold the sink off while input keeps coming, so the unit backs up
                if (p == 1 && n == 20)
                    hold_req <= 1'b1;
                // Pause input until the unit has fully emptied, then resume
                if (p == 2 && n == 120)
                    drain();
                offer(random_req());
            end
            drain();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
